### hw/rtl/diff_drive_odometry_assert.svh
// Assertion macros for the odometry block
`ifndef DIFF_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_ASSERT_SVH
`ifndef SYNTHESIS
`define DDO_ASSERT_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define DDO_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define DDO_ASSERT_IMPL(label, clk, rst_n, a, c)
`define DDO_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

### hw/rtl/ddo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_pkg
// Commands, register indexes and the CORDIC arc table of the odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;
	localparam logic [1:0] FUNC_UPDATE = 2'd0;
	localparam logic [1:0] FUNC_SET    = 2'd1;
	localparam logic [1:0] FUNC_RESET  = 2'd2;

	localparam logic [1:0] REG_DPT = 2'd0;
	localparam logic [1:0] REG_SX  = 2'd1;
	localparam logic [1:0] REG_SY  = 2'd2;
	localparam logic [1:0] REG_SH  = 2'd3;

	localparam int ArcEntries = 24;
	localparam longint CordicGain = 64'sd652032874;

	function automatic logic [31:0] arc(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
			5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
			5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
			5'd6: r = 32'd10680862;   5'd7: r = 32'd5340245;
			5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
			5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
			5'd14: r = 32'd41721;     5'd15: r = 32'd20860;
			5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
			5'd18: r = 32'd2607;      5'd19: r = 32'd1303;
			5'd20: r = 32'd651;       5'd21: r = 32'd325;
			5'd22: r = 32'd162;       5'd23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

### hw/rtl/diff_drive_odometry.sv
`timescale 1ns / 1ps
`default_nettype none
// An update runs the serial distance multiply, the CORDIC and the two serial
// multiplies in that order before the result is valid; set pose, reset and unused
// codes go straight from accept to the result state. One item is in flight at a
// time; the next is taken the cycle after the result is taken.
// Asynchronous active-low reset clears pose, counts, offsets and registers.
// ----------------------------------------------------------------------------
// diff_drive_odometry
// Encoder and IMU heading odometry with bit-serial multiplies and a CORDIC.
// ----------------------------------------------------------------------------
module diff_drive_odometry #(
	parameter int ANGLE_BITS   = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         func,
	input  wire logic signed [31:0] left_ticks,
	input  wire logic signed [31:0] right_ticks,
	input  wire logic signed [15:0] raw_yaw,
	input  wire logic signed [31:0] new_x,
	input  wire logic signed [31:0] new_y,
	input  wire logic signed [15:0] new_heading,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      pose_x,
	output logic signed [31:0]      pose_y,
	output logic signed [15:0]      pose_heading,
	output logic                    clipped
);
	import ddo_pkg::*;

	localparam int AW = ANGLE_BITS;
	localparam int SW = (CORDIC_STEPS < 32) ? 5 : 6;
	localparam logic signed [AW-1:0] Quarter = AW'(1) <<< (AW - 2);

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL_D, ST_CORDIC, ST_MUL_X, ST_MUL_Y, ST_DONE
	} state_t;

	state_t state_q;
	logic [23:0] dpt_q;
	logic [31:0] sx_q, sy_q;
	logic [15:0] sh_q;
	logic [31:0] prev_l_q, prev_r_q, px_q, py_q;
	logic [15:0] last_yaw_q, offset_q, head_q;
	logic        clip_q;
	// serial multiplier: multiplicand shifted in, multiplier consumed LSB first
	logic signed [63:0] acc_q, mcand_q;
	logic [32:0]        mplier_q;
	logic [5:0]         cnt_q;
	logic signed [48:0] dist_q;
	logic signed [33:0] cx_q, cy_q;
	logic signed [AW-1:0] cz_q;
	logic [SW-1:0]        it_q;
	logic                 neg_q;
	logic signed [16:0]   sin_q;

	// pose outputs follow the state
	assign pose_x       = px_q;
	assign pose_y       = py_q;
	assign pose_heading = head_q;
	assign clipped      = clip_q;
	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = (state_q == ST_DONE);
	assign pready       = 1'b1;

	// register read back
	always_comb begin
		unique case (paddr[3:2])
			REG_DPT: prdata = {8'd0, dpt_q};
			REG_SX:  prdata = sx_q;
			REG_SY:  prdata = sy_q;
			REG_SH:  prdata = {16'd0, sh_q};
			default: prdata = '0;
		endcase
	end

	// combinational helpers
	logic signed [32:0] dl_w, dr_w, sum_w;
	logic signed [AW-1:0] a_w, af_w, tab_w;
	logic                 fold_w;
	logic signed [33:0] xs_w, ys_w;
	logic signed [48:0] rnd_w;
	logic signed [16:0] q_x_w, q_y_w;
	logic signed [47:0] qx_full, qy_full;
	logic signed [49:0] base_w, nv_w;
	logic [31:0]        arc_w, tab_wide;
	logic signed [63:0] prod_w;

	always_comb begin
		dl_w  = 33'(signed'(left_ticks - prev_l_q));
		dr_w  = 33'(signed'(right_ticks - prev_r_q));
		sum_w = dl_w + dr_w;
		if (AW >= 16) a_w = AW'(signed'(raw_yaw - offset_q)) <<< (AW - 16);
		else a_w = AW'(signed'(raw_yaw - offset_q) >>> (16 - AW));
		fold_w = (a_w > Quarter) || (a_w < -Quarter);
		af_w   = fold_w ? (a_w + (Quarter <<< 1)) : a_w;
		arc_w    = arc(5'(it_q));
		tab_wide = (arc_w + (32'd1 << (31 - AW))) >> (32 - AW);
		tab_w    = AW'(tab_wide);
		xs_w = cx_q >>> it_q;
		ys_w = cy_q >>> it_q;
		qx_full = 48'(neg_q ? -cx_q : cx_q) + 48'sd16384;
		qy_full = 48'(neg_q ? -cy_q : cy_q) + 48'sd16384;
		q_x_w = (qx_full >>> 15 > 48'sd32767) ? 17'sd32767 :
			(qx_full >>> 15 < -48'sd32767) ? -17'sd32767 : 17'(qx_full >>> 15);
		q_y_w = (qy_full >>> 15 > 48'sd32767) ? 17'sd32767 :
			(qy_full >>> 15 < -48'sd32767) ? -17'sd32767 : 17'(qy_full >>> 15);
		prod_w = acc_q + 64'sd16384;
		rnd_w  = 49'(prod_w >>> 15);
		base_w = 50'(signed'(state_q == ST_MUL_X ? px_q : py_q));
		nv_w   = base_w + 50'(rnd_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dpt_q <= '0; sx_q <= '0; sy_q <= '0; sh_q <= '0;
			prev_l_q <= '0; prev_r_q <= '0; px_q <= '0; py_q <= '0;
			last_yaw_q <= '0; offset_q <= '0; head_q <= '0; clip_q <= 1'b0;
			acc_q <= '0; mcand_q <= '0; mplier_q <= '0; cnt_q <= '0;
			dist_q <= '0; cx_q <= '0; cy_q <= '0; cz_q <= '0; it_q <= '0;
			neg_q <= 1'b0; sin_q <= '0;
		end else begin
			// configuration writes
			if (psel && penable && pwrite) begin
				unique case (paddr[3:2])
					REG_DPT: dpt_q <= pwdata[23:0];
					REG_SX:  sx_q <= pwdata;
					REG_SY:  sy_q <= pwdata;
					REG_SH:  sh_q <= pwdata[15:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					clip_q <= 1'b0;
					case (func)
						FUNC_UPDATE: begin
							prev_l_q <= left_ticks;
							prev_r_q <= right_ticks;
							last_yaw_q <= raw_yaw;
							head_q <= raw_yaw - offset_q;
							cz_q <= af_w;
							neg_q <= fold_w;
							acc_q <= '0;
							mcand_q <= 64'(sum_w);
							mplier_q <= 33'(dpt_q);
							cnt_q <= 6'd24;
							state_q <= ST_MUL_D;
						end
						FUNC_SET: begin
							offset_q <= last_yaw_q - new_heading;
							px_q <= new_x; py_q <= new_y; head_q <= new_heading;
							state_q <= ST_DONE;
						end
						FUNC_RESET: begin
							offset_q <= last_yaw_q - sh_q;
							px_q <= sx_q; py_q <= sy_q; head_q <= sh_q;
							prev_l_q <= '0; prev_r_q <= '0;
							state_q <= ST_DONE;
						end
						default: state_q <= ST_DONE;
					endcase
				end
				// distance: add one shifted multiplicand per cycle
				ST_MUL_D: begin
					if (cnt_q == 6'd0) begin
						dist_q <= 49'((acc_q + 64'sd256) >>> 9);
						cx_q <= 34'(CordicGain); cy_q <= '0; it_q <= '0;
						state_q <= ST_CORDIC;
					end else begin
						if (mplier_q[0]) acc_q <= acc_q + mcand_q;
						mcand_q <= mcand_q <<< 1;
						mplier_q <= mplier_q >> 1;
						cnt_q <= cnt_q - 6'd1;
					end
				end
				// one CORDIC micro-rotation per cycle
				ST_CORDIC: begin
					if (32'(it_q) == CORDIC_STEPS || 32'(it_q) == ArcEntries) begin
						sin_q <= q_y_w;
						acc_q <= '0;
						mcand_q <= 64'(dist_q);
						mplier_q <= 33'(q_x_w);
						cnt_q <= 6'd17;
						state_q <= ST_MUL_X;
					end else begin
						if (cz_q >= 0) begin
							cx_q <= cx_q - ys_w; cy_q <= cy_q + xs_w; cz_q <= cz_q - tab_w;
						end else begin
							cx_q <= cx_q + ys_w; cy_q <= cy_q - xs_w; cz_q <= cz_q + tab_w;
						end
						it_q <= it_q + SW'(1);
					end
				end
				// signed 17-bit multiplier: top bit weighs negative
				ST_MUL_X, ST_MUL_Y: begin
					if (cnt_q == 6'd0) begin
						if (nv_w > 50'sd2147483647) begin
							clip_q <= 1'b1;
						end else if (nv_w < -50'sd2147483648) begin
							clip_q <= 1'b1;
						end
						if (state_q == ST_MUL_X) begin
							px_q <= (nv_w > 50'sd2147483647) ? 32'h7fffffff :
								(nv_w < -50'sd2147483648) ? 32'h80000000 : nv_w[31:0];
							acc_q <= '0;
							mcand_q <= 64'(dist_q);
							mplier_q <= 33'(sin_q);
							cnt_q <= 6'd17;
							state_q <= ST_MUL_Y;
						end else begin
							py_q <= (nv_w > 50'sd2147483647) ? 32'h7fffffff :
								(nv_w < -50'sd2147483648) ? 32'h80000000 : nv_w[31:0];
							state_q <= ST_DONE;
						end
					end else begin
						if (mplier_q[0])
							acc_q <= (cnt_q == 6'd1) ? acc_q - mcand_q : acc_q + mcand_q;
						mcand_q <= mcand_q <<< 1;
						mplier_q <= mplier_q >> 1;
						cnt_q <= cnt_q - 6'd1;
					end
				end
				ST_DONE: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`include "diff_drive_odometry_assert.svh"
	`DDO_ASSERT_IMPL(a_excl, clk, arst_n, 1'b1, !(in_ready && out_valid))
	`DDO_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(pose_x))
	`DDO_ASSERT_NEXT(a_take, clk, arst_n, in_valid && in_ready && func != FUNC_UPDATE, out_valid)
endmodule
`default_nettype wire
